// ----- hw/rtl/msr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants and types for the modular square root block.
// ----------------------------------------------------------------------------
package msr_pkg;

   // search bound for the least quadratic non-residue
   localparam int unsigned NONRES_LIMIT = 4096;

   // command/status between the sequencer and the multiply unit
   typedef struct packed {
      logic start;
   } mul_cmd_type;

   typedef struct packed {
      logic done;
      logic busy;
   } mul_sts_type;

   typedef enum logic [22:0] {
      ST_IDLE  = 23'h000001,
      ST_RED   = 23'h000002,
      ST_SHIFT = 23'h000004,
      ST_ZTEST = 23'h000008,
      ST_ZRES  = 23'h000010,
      ST_GOTC  = 23'h000020,
      ST_GOTT  = 23'h000040,
      ST_GOTX  = 23'h000080,
      ST_LOOP  = 23'h000100,
      ST_ORD   = 23'h000200,
      ST_ORDW  = 23'h000400,
      ST_BSQ   = 23'h000800,
      ST_BSQW  = 23'h001000,
      ST_XW    = 23'h002000,
      ST_T1W   = 23'h004000,
      ST_T2W   = 23'h008000,
      ST_CW    = 23'h010000,
      ST_CHECK = 23'h020000,
      ST_CHKW  = 23'h040000,
      ST_PCHK  = 23'h080000,
      ST_PMA   = 23'h100000,
      ST_PMB   = 23'h200000,
      ST_X3    = 23'h400000
   } state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/modular_square_root.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_square_root
// Square root of a value modulo a prime (Tonelli-Shanks with fast paths).
// ----------------------------------------------------------------------------
// One word at a time: start is taken when busy is low, and the result appears
// on rsp_root / rsp_no_root for one cycle with rsp_valid, which cannot be held
// off. All arithmetic runs on one bit-serial modular multiplier; the first
// reduction costs one product, a modular power about 2*MOD_BITS products, the
// non-residue search one power per candidate, and the final squaring check one
// product. A modulus with no small non-residue can take up to about 4096 powers.
// ----------------------------------------------------------------------------
module modular_square_root import msr_pkg::*; #(
   parameter int unsigned MOD_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [31:0] req_value,
   input  wire logic [31:0] req_modulus,
   output      logic        rsp_valid,
   output      logic [31:0] rsp_root,
   output      logic        rsp_no_root
);

   localparam int unsigned W  = MOD_BITS;
   localparam int unsigned MW = $clog2(MOD_BITS + 1);

   state_type     state_ff, ret_ff;
   logic [W-1:0]  p_ff, a_ff, q_ff, z_ff, c_ff, t_ff, x_ff, b_ff, sq_ff, r_ff;
   logic [W-1:0]  pb_ff, pe_ff, pacc_ff;
   logic [MW-1:0] mm_ff, i_ff, j_ff;
   logic          rsp_valid_ff, rsp_no_root_ff;
   logic [31:0]   rsp_root_ff;
   mul_cmd_type   mcmd_ff;
   mul_sts_type   msts;
   logic [W-1:0]  ma_ff, mb_ff, mres;
   logic [W:0]    p_inc;
   logic [W:0]    q_inc;
   logic [MW:0]   j_inc;
   logic [MW:0]   mm_gap;

   assign p_inc  = {1'b0, p_ff} + 1'b1;
   assign q_inc  = {1'b0, q_ff} + 1'b1;
   assign j_inc  = {1'b0, j_ff} + 1'b1;
   assign mm_gap = {1'b0, mm_ff} - {1'b0, i_ff};

   msr_mulmod #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mcmd_ff),
      .op_a    (ma_ff),
      .op_b    (mb_ff),
      .modulus (p_ff),
      .sts     (msts),
      .res     (mres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         mcmd_ff.start <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mcmd_ff.start <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  p_ff <= req_modulus[W-1:0];
                  if (req_modulus[W-1:0] < W'(2)) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_root_ff    <= '0;
                     rsp_no_root_ff <= 1'b1;
                  end else begin
                     // value mod p as value * 1
                     ma_ff         <= req_value[W-1:0];
                     mb_ff         <= W'(1);
                     mcmd_ff.start <= 1'b1;
                     state_ff      <= ST_RED;
                  end
               end
            end
            ST_RED: begin
               if (msts.done) begin
                  a_ff <= mres;
                  if (mres == '0) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_root_ff    <= '0;
                     rsp_no_root_ff <= 1'b0;
                     state_ff       <= ST_IDLE;
                  end else if (p_ff == W'(2)) begin
                     r_ff     <= W'(mres[0]);
                     state_ff <= ST_CHECK;
                  end else if (p_ff[1:0] == 2'b11) begin
                     pb_ff    <= mres;
                     pe_ff    <= W'(p_inc >> 2);
                     pacc_ff  <= W'(1);
                     ret_ff   <= ST_X3;
                     state_ff <= ST_PCHK;
                  end else begin
                     q_ff     <= p_ff - 1'b1;
                     mm_ff    <= '0;
                     state_ff <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               if (q_ff != '0 && !q_ff[0]) begin
                  q_ff  <= q_ff >> 1;
                  mm_ff <= mm_ff + 1'b1;
               end else begin
                  z_ff     <= W'(2);
                  state_ff <= ST_ZTEST;
               end
            end
            ST_ZTEST: begin
               if (z_ff < p_ff && 33'(z_ff) < 33'(NONRES_LIMIT)) begin
                  pb_ff    <= z_ff;
                  pe_ff    <= (p_ff - 1'b1) >> 1;
                  pacc_ff  <= W'(1);
                  ret_ff   <= ST_ZRES;
                  state_ff <= ST_PCHK;
               end else begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_root_ff    <= '0;
                  rsp_no_root_ff <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            ST_ZRES: begin
               if (pacc_ff == p_ff - 1'b1) begin
                  pb_ff    <= z_ff;
                  pe_ff    <= q_ff;
                  pacc_ff  <= W'(1);
                  ret_ff   <= ST_GOTC;
                  state_ff <= ST_PCHK;
               end else begin
                  z_ff     <= z_ff + 1'b1;
                  state_ff <= ST_ZTEST;
               end
            end
            ST_GOTC: begin
               c_ff     <= pacc_ff;
               pb_ff    <= a_ff;
               pe_ff    <= q_ff;
               pacc_ff  <= W'(1);
               ret_ff   <= ST_GOTT;
               state_ff <= ST_PCHK;
            end
            ST_GOTT: begin
               t_ff     <= pacc_ff;
               pb_ff    <= a_ff;
               pe_ff    <= W'(q_inc >> 1);
               pacc_ff  <= W'(1);
               ret_ff   <= ST_GOTX;
               state_ff <= ST_PCHK;
            end
            ST_GOTX: begin
               x_ff     <= pacc_ff;
               state_ff <= ST_LOOP;
            end
            ST_LOOP: begin
               if (t_ff == W'(1)) begin
                  r_ff     <= x_ff;
                  state_ff <= ST_CHECK;
               end else if (t_ff == '0) begin
                  r_ff     <= '0;
                  state_ff <= ST_CHECK;
               end else begin
                  sq_ff    <= t_ff;
                  i_ff     <= '0;
                  state_ff <= ST_ORD;
               end
            end
            ST_ORD: begin
               if (sq_ff != W'(1) && i_ff < mm_ff) begin
                  ma_ff         <= sq_ff;
                  mb_ff         <= sq_ff;
                  mcmd_ff.start <= 1'b1;
                  state_ff      <= ST_ORDW;
               end else if (i_ff >= mm_ff) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_root_ff    <= '0;
                  rsp_no_root_ff <= 1'b1;
                  state_ff       <= ST_IDLE;
               end else begin
                  b_ff     <= c_ff;
                  j_ff     <= '0;
                  state_ff <= ST_BSQ;
               end
            end
            ST_ORDW: begin
               if (msts.done) begin
                  sq_ff    <= mres;
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_ORD;
               end
            end
            ST_BSQ: begin
               mcmd_ff.start <= 1'b1;
               if (j_inc < mm_gap) begin
                  ma_ff    <= b_ff;
                  mb_ff    <= b_ff;
                  state_ff <= ST_BSQW;
               end else begin
                  ma_ff    <= x_ff;
                  mb_ff    <= b_ff;
                  state_ff <= ST_XW;
               end
            end
            ST_BSQW: begin
               if (msts.done) begin
                  b_ff     <= mres;
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_BSQ;
               end
            end
            ST_XW: begin
               if (msts.done) begin
                  x_ff          <= mres;
                  ma_ff         <= t_ff;
                  mb_ff         <= b_ff;
                  mcmd_ff.start <= 1'b1;
                  state_ff      <= ST_T1W;
               end
            end
            ST_T1W: begin
               if (msts.done) begin
                  ma_ff         <= mres;
                  mb_ff         <= b_ff;
                  mcmd_ff.start <= 1'b1;
                  state_ff      <= ST_T2W;
               end
            end
            ST_T2W: begin
               if (msts.done) begin
                  t_ff          <= mres;
                  ma_ff         <= b_ff;
                  mb_ff         <= b_ff;
                  mcmd_ff.start <= 1'b1;
                  state_ff      <= ST_CW;
               end
            end
            ST_CW: begin
               if (msts.done) begin
                  c_ff     <= mres;
                  mm_ff    <= i_ff;
                  state_ff <= ST_LOOP;
               end
            end
            ST_X3: begin
               r_ff     <= pacc_ff;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (r_ff < p_ff) begin
                  ma_ff         <= r_ff;
                  mb_ff         <= r_ff;
                  mcmd_ff.start <= 1'b1;
                  state_ff      <= ST_CHKW;
               end else begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_root_ff    <= '0;
                  rsp_no_root_ff <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            ST_CHKW: begin
               if (msts.done) begin
                  rsp_valid_ff <= 1'b1;
                  if (mres == a_ff) begin
                     rsp_root_ff    <= 32'(r_ff);
                     rsp_no_root_ff <= 1'b0;
                  end else begin
                     rsp_root_ff    <= '0;
                     rsp_no_root_ff <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            // modular power, exponent scanned from its low bit
            ST_PCHK: begin
               if (pe_ff == '0) begin
                  state_ff <= ret_ff;
               end else begin
                  mcmd_ff.start <= 1'b1;
                  if (pe_ff[0]) begin
                     ma_ff    <= pacc_ff;
                     mb_ff    <= pb_ff;
                     state_ff <= ST_PMA;
                  end else begin
                     ma_ff    <= pb_ff;
                     mb_ff    <= pb_ff;
                     state_ff <= ST_PMB;
                  end
               end
            end
            ST_PMA: begin
               if (msts.done) begin
                  pacc_ff       <= mres;
                  ma_ff         <= pb_ff;
                  mb_ff         <= pb_ff;
                  mcmd_ff.start <= 1'b1;
                  state_ff      <= ST_PMB;
               end
            end
            ST_PMB: begin
               if (msts.done) begin
                  pb_ff    <= mres;
                  pe_ff    <= pe_ff >> 1;
                  state_ff <= ST_PCHK;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_root    = rsp_root_ff;
   assign rsp_no_root = rsp_no_root_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/msr_mulmod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier: res = (a * b) mod p, one bit of a per cycle.
// b must be below p; a may be any value.
// ----------------------------------------------------------------------------
module msr_mulmod import msr_pkg::*; #(
   parameter int unsigned W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mul_cmd_type  cmd,
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   input  wire logic [W-1:0] modulus,
   output      mul_sts_type  sts,
   output      logic [W-1:0] res
);

   localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  sh_ff;
   logic [W-1:0]  b_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    dbl;
   logic [W:0]    dbl_red;
   logic [W:0]    sum;

   // double, reduce, add selected multiplicand, reduce
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum     = dbl_red + {1'b0, (sh_ff[W-1] ? b_ff : {W{1'b0}})};
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      acc_in = sum[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            acc_ff  <= '0;
            sh_ff   <= op_a;
            b_ff    <= op_b;
            cnt_ff  <= CW'(W - 1);
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            sh_ff  <= {sh_ff[W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res      = acc_ff;
   assign sts.done = done_ff;
   assign sts.busy = busy_ff;

endmodule
`default_nettype wire
